// ===== hw/rtl/sldf_pkg.sv =====
// ----------------------------------------------------------------------------
// sldf_pkg
// Shared types and constants for the sync/length frame deframer.
// ----------------------------------------------------------------------------
package sldf_pkg;

   localparam int ByteWidth = 8;
   localparam int LenWidth  = 16;

   localparam logic [ByteWidth-1:0] SyncFirst   = 8'hAA;
   localparam logic [ByteWidth-1:0] SyncSecond  = 8'h55;
   localparam logic [LenWidth-1:0]  MaxLenReset = 16'hFFFF;

   typedef enum logic [4:0] {
      PH_HUNT    = 5'b00001,
      PH_SYNC2   = 5'b00010,
      PH_LEN_LO  = 5'b00100,
      PH_LEN_HI  = 5'b01000,
      PH_PAYLOAD = 5'b10000
   } phase_type;

   typedef struct packed {
      logic [ByteWidth-1:0] data_byte;
      logic                 last;
      logic                 empty_frame;
      logic [LenWidth-1:0]  frame_length;
   } rsp_type;

endpackage

// ===== hw/rtl/sldf_stream_if.sv =====
// ----------------------------------------------------------------------------
// sldf_req_if / sldf_rsp_if
// Valid/ready channels for received bytes and deframed result beats.
// ----------------------------------------------------------------------------
interface sldf_req_if
   import sldf_pkg::*;
   ();
   logic                 valid;
   logic                 ready;
   logic [ByteWidth-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sldf_rsp_if
   import sldf_pkg::*;
   ();
   logic                 valid;
   logic                 ready;
   logic [ByteWidth-1:0] data_byte;
   logic                 last;
   logic                 empty_frame;
   logic [LenWidth-1:0]  frame_length;

   modport source (output valid, output data_byte, output last, output empty_frame,
                   output frame_length, input ready);
   modport sink   (input valid, input data_byte, input last, input empty_frame,
                   input frame_length, output ready);
endinterface

// ===== hw/rtl/sync_length_frame_deframer.sv =====
// ----------------------------------------------------------------------------
// sync_length_frame_deframer
// Result beats pass through the output register (or the skid) to rsp.
// Throughput: one byte per cycle while req is ready; the phase update and
// the count compare finish in the accept cycle. A two-entry output stage
// (register + skid) keeps req ready while one result beat waits.
// Reset: synchronous; hunting for sync, counters cleared, max_length 65535.
// ----------------------------------------------------------------------------
module sync_length_frame_deframer
   import sldf_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_we,
   input  logic [LenWidth-1:0] csr_wdata,
   sldf_req_if.sink            req_if,
   sldf_rsp_if.source          rsp_if
);

   phase_type            phase_ff, phase_in;
   logic [ByteWidth-1:0] length_low_ff, length_low_in;
   logic [LenWidth-1:0]  target_ff, target_in;
   logic [LenWidth-1:0]  delivered_ff, delivered_in;
   logic [LenWidth-1:0]  max_len_ff;

   rsp_type out_ff, out_in, skid_ff, skid_in, res;
   logic    out_valid_ff, out_valid_in, skid_valid_ff, skid_valid_in, res_valid;

   logic                 accept, out_take;
   logic [ByteWidth-1:0] b;
   logic [LenWidth-1:0]  len, capped, count_next;

   assign b        = req_if.rx_byte;
   assign accept   = req_if.valid && req_if.ready;
   assign out_take = out_valid_ff && rsp_if.ready;
   assign req_if.ready = !skid_valid_ff;

   assign len        = {b, length_low_ff};
   assign capped     = (len < max_len_ff) ? len : max_len_ff;
   assign count_next = delivered_ff + 1'b1;

   always_comb begin
      phase_in      = phase_ff;
      length_low_in = length_low_ff;
      target_in     = target_ff;
      delivered_in  = delivered_ff;
      res           = '0;
      res_valid     = 1'b0;
      if (accept) begin
         unique case (phase_ff)
            PH_SYNC2: begin
               phase_in = (b == SyncSecond) ? PH_LEN_LO : PH_HUNT;
            end
            PH_LEN_LO: begin
               length_low_in = b;
               phase_in      = PH_LEN_HI;
            end
            PH_LEN_HI: begin
               target_in    = capped;
               delivered_in = '0;
               if (capped == '0) begin
                  phase_in        = PH_HUNT;
                  res_valid       = 1'b1;
                  res.last        = 1'b1;
                  res.empty_frame = 1'b1;
               end else begin
                  phase_in = PH_PAYLOAD;
               end
            end
            PH_PAYLOAD: begin
               delivered_in  = count_next;
               res_valid     = 1'b1;
               res.data_byte = b;
               if (count_next >= target_ff) begin
                  phase_in         = PH_HUNT;
                  res.last         = 1'b1;
                  res.frame_length = count_next;
               end
            end
            default: begin
               phase_in = (b == SyncFirst) ? PH_SYNC2 : PH_HUNT;
            end
         endcase
      end
   end

   // output register plus skid; skid drains first
   always_comb begin
      out_in        = out_ff;
      skid_in       = skid_ff;
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (skid_valid_ff) begin
         if (out_take) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (res_valid) begin
         if (!out_valid_ff || out_take) begin
            out_in       = res;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = res;
            skid_valid_in = 1'b1;
         end
      end else if (out_take) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_HUNT;
         length_low_ff <= '0;
         target_ff     <= '0;
         delivered_ff  <= '0;
         max_len_ff    <= MaxLenReset;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         length_low_ff <= length_low_in;
         target_ff     <= target_in;
         delivered_ff  <= delivered_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
         if (csr_we) begin
            max_len_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_if.valid        = out_valid_ff;
   assign rsp_if.data_byte    = out_ff.data_byte;
   assign rsp_if.last         = out_ff.last;
   assign rsp_if.empty_frame  = out_ff.empty_frame;
   assign rsp_if.frame_length = out_ff.frame_length;

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid holds a beat while output register is empty");

   a_payload_count: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_PAYLOAD) |-> (target_ff != '0 && delivered_ff < target_ff))
      else $error("payload phase with count at or past target");

   a_empty_beat: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.empty_frame) |->
         (out_ff.last && out_ff.data_byte == '0 && out_ff.frame_length == '0))
      else $error("malformed empty-frame beat");

   a_last_length: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.last && !out_ff.empty_frame) |-> (out_ff.frame_length != '0))
      else $error("last payload beat with zero frame length");

endmodule

// ===== tb/sync_length_frame_deframer_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sync_length_frame_deframer_test
// Drives received bytes into the deframer and checks every result beat
// against an in-bench model of the sync/length phase machine. The run covers
// sync hunting and mismatches, empty and capped frames, length cap writes
// between frames and mid-frame, random frames mixed with noise and broken
// headers, random idling on both channels and one long receiver hold-off.
// ----------------------------------------------------------------------------
module sync_length_frame_deframer_test;
   import sldf_pkg::*;

   typedef logic [ByteWidth-1:0] byte_seq_type [$];

   // Models the deframer and holds the result beats still owed by the block.
   class frame_checker;
      phase_type            phase;
      logic [ByteWidth-1:0] len_low;
      logic [LenWidth-1:0]  target;
      logic [LenWidth-1:0]  delivered;
      logic [LenWidth-1:0]  cap;
      rsp_type              owed_beats[$];
      int                   errors;
      int                   bytes_seen;
      int                   beats_checked;
      int                   frames_done;
      int                   empty_frames;
      int                   capped_frames;

      function new();
         cap           = MaxLenReset;
         phase         = PH_HUNT;
         len_low       = '0;
         target        = '0;
         delivered     = '0;
         errors        = 0;
         bytes_seen    = 0;
         beats_checked = 0;
         frames_done   = 0;
         empty_frames  = 0;
         capped_frames = 0;
      endfunction

      function void set_cap(logic [LenWidth-1:0] value);
         cap = value;
      endfunction

      function int pending();
         return owed_beats.size();
      endfunction

      function void note_byte(logic [ByteWidth-1:0] b);
         rsp_type             beat;
         logic [LenWidth-1:0] len;
         beat = '0;
         bytes_seen++;
         case (phase)
            PH_SYNC2: begin
               phase = (b == SyncSecond) ? PH_LEN_LO : PH_HUNT;
            end
            PH_LEN_LO: begin
               len_low = b;
               phase   = PH_LEN_HI;
            end
            PH_LEN_HI: begin
               len       = {b, len_low};
               target    = (len < cap) ? len : cap;
               delivered = '0;
               if (len > cap) capped_frames++;
               if (target == '0) begin
                  phase            = PH_HUNT;
                  beat.last        = 1'b1;
                  beat.empty_frame = 1'b1;
                  owed_beats.push_back(beat);
               end else begin
                  phase = PH_PAYLOAD;
               end
            end
            PH_PAYLOAD: begin
               delivered      = delivered + 1'b1;
               beat.data_byte = b;
               if (delivered >= target) begin
                  phase             = PH_HUNT;
                  beat.last         = 1'b1;
                  beat.frame_length = delivered;
               end
               owed_beats.push_back(beat);
            end
            default: begin
               phase = (b == SyncFirst) ? PH_SYNC2 : PH_HUNT;
            end
         endcase
      endfunction

      function void check_field(string field, logic [LenWidth-1:0] want,
                                logic [LenWidth-1:0] got);
         if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h",
                     $time, field, want, got);
         end
      endfunction

      function void check_beat(rsp_type got);
         rsp_type want;
         if (owed_beats.size() == 0) begin
            errors++;
            $display("%0t: unexpected beat: expected none, actual %p", $time, got);
            return;
         end
         want = owed_beats.pop_front();
         beats_checked++;
         if (want.last) frames_done++;
         if (want.empty_frame) empty_frames++;
         check_field("data_byte", LenWidth'(want.data_byte), LenWidth'(got.data_byte));
         check_field("last", LenWidth'(want.last), LenWidth'(got.last));
         check_field("empty_frame", LenWidth'(want.empty_frame),
                     LenWidth'(got.empty_frame));
         check_field("frame_length", want.frame_length, got.frame_length);
      endfunction
   endclass

   logic                clock = 1'b0;
   logic                reset;
   logic                csr_we;
   logic [LenWidth-1:0] csr_wdata;
   bit                  idle_on = 1'b1;
   bit                  hold_req = 1'b0;
   int                  cap_writes = 0;
   frame_checker        chk = new();

   sldf_req_if req_ch ();
   sldf_rsp_if rsp_ch ();

   sync_length_frame_deframer dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_if    (req_ch),
      .rsp_if    (rsp_ch)
   );

   always begin
      #1ns clock = 1'b1;
      #1ns clock = 1'b0;
   end

   initial begin
      #400us;
      $display("FAIL sync_length_frame_deframer");
      $finish;
   end

   // Result side: random ready, plus a long hold-off on request.
   initial begin
      int      stall_left;
      rsp_type got;
      stall_left   = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready) begin
            got.data_byte    = rsp_ch.data_byte;
            got.last         = rsp_ch.last;
            got.empty_frame  = rsp_ch.empty_frame;
            got.frame_length = rsp_ch.frame_length;
            chk.check_beat(got);
         end
         if (hold_req) begin
            hold_req   = 1'b0;
            stall_left = 150;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= !(idle_on && $urandom_range(99) < 11);
         end
      end
   end

   task automatic send_byte(input logic [ByteWidth-1:0] b);
      while (idle_on && $urandom_range(99) < 11) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.rx_byte <= b;
      do @(posedge clock); while (!req_ch.ready);
      chk.note_byte(b);
   endtask

   task automatic send_bytes(input byte_seq_type seq);
      foreach (seq[i]) send_byte(seq[i]);
   endtask

   // Header plus payload; bytes past the cap go out as hunt input.
   task automatic send_frame(input logic [LenWidth-1:0] len, input int extra_max);
      int deliver;
      int count;
      deliver = (len < chk.cap) ? len : chk.cap;
      count   = deliver;
      if (len > deliver) count += ((len - deliver) < extra_max) ? (len - deliver)
                                                               : $urandom_range(extra_max);
      send_bytes('{SyncFirst, SyncSecond, len[7:0], len[15:8]});
      repeat (count) send_byte(ByteWidth'($urandom_range(255)));
   endtask

   task automatic wait_quiet();
      req_ch.valid <= 1'b0;
      while (chk.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_cap(input logic [LenWidth-1:0] value);
      wait_quiet();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      chk.set_cap(value);
      cap_writes++;
   endtask

   task automatic send_random_unit();
      int                  pick;
      logic [LenWidth-1:0] len;
      pick = $urandom_range(99);
      if (pick < 12) begin
         repeat ($urandom_range(1, 4)) send_byte(ByteWidth'($urandom_range(255)));
      end else if (pick < 16) begin
         send_bytes('{SyncFirst, ByteWidth'($urandom_range(255)) & 8'hFE});
      end else if (pick < 20) begin
         send_bytes('{SyncFirst, SyncFirst, SyncSecond});
      end else begin
         pick = $urandom_range(9);
         if (pick == 0) begin
            len = '0;
         end else if (pick == 1) begin
            len = (chk.cap <= 48) ? LenWidth'($urandom_range(65535))
                                  : LenWidth'($urandom_range(48));
         end else if (pick == 2 && chk.cap <= 48) begin
            len = chk.cap + LenWidth'($urandom_range(1));
         end else begin
            len = LenWidth'($urandom_range(1, 24));
         end
         send_frame(len, 6);
      end
   endtask

   initial begin
      logic [LenWidth-1:0] cap_pick;
      int                  phase_no;
      int                  phase_start;
      reset          = 1'b1;
      csr_we         = 1'b0;
      csr_wdata      = '0;
      req_ch.valid   = 1'b0;
      req_ch.rx_byte = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: hunt noise, both sync mismatches, a short frame, empty frames.
      send_bytes('{8'h00, SyncFirst, 8'h54, SyncFirst, SyncFirst, SyncSecond});
      send_bytes('{SyncFirst, SyncSecond, 8'h02, 8'h00, 8'h00, 8'hFF});
      send_bytes('{SyncFirst, SyncSecond, 8'h00, 8'h00});
      write_cap(16'd0);
      send_bytes('{SyncFirst, SyncSecond, 8'h03, 8'h00});
      write_cap(16'd1);
      send_bytes('{SyncFirst, SyncSecond, 8'hFF, 8'hFF, 8'h80, 8'h7F});
      // Cap is latched with the length; a write after it waits for the next frame.
      send_bytes('{SyncFirst, SyncSecond, 8'h03, 8'h00});
      write_cap(MaxLenReset);
      send_bytes('{8'h11, 8'h22});

      phase_no = 0;
      while (chk.bytes_seen < 1450) begin
         if (phase_no == 0) begin
            cap_pick = MaxLenReset;
         end else begin
            case ($urandom_range(5))
               0:       cap_pick = '0;
               1:       cap_pick = 16'd1;
               2:       cap_pick = MaxLenReset;
               3:       cap_pick = LenWidth'($urandom_range(65535));
               default: cap_pick = LenWidth'($urandom_range(2, 40));
            endcase
         end
         write_cap(cap_pick);
         idle_on     = (phase_no != 4);
         phase_start = chk.bytes_seen;
         if (phase_no == 0) begin
            // Receiver stalls while a long frame keeps coming.
            hold_req = 1'b1;
            send_frame(16'd48, 0);
         end
         while (chk.bytes_seen - phase_start < 110) send_random_unit();
         phase_no++;
      end

      wait_quiet();
      repeat (6) @(posedge clock);
      $display("Covered %0d bytes and %0d result beats over %0d cap settings.",
               chk.bytes_seen, chk.beats_checked, cap_writes);
      $display("Frames closed: %0d, of which %0d empty; %0d lengths hit the cap.",
               chk.frames_done, chk.empty_frames, chk.capped_frames);
      if (chk.errors == 0) begin
         $display("PASS sync_length_frame_deframer");
      end else begin
         $display("FAIL sync_length_frame_deframer");
      end
      $finish;
   end

endmodule
